[rtl/plrf_pkg.sv]
// ============================================================================
// Paged log record framer package
// Shared constants, command and result codes, and the result item type.
// ============================================================================
package plrf_pkg;

    localparam int PAGE_BYTES  = 4096;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int BATCH_BYTES = 1048576;
    localparam int WORD_BYTES  = 4;

    localparam int ROOM_W  = PAGE_SHIFT + 1;
    localparam int LEN_W   = 21;
    localparam int OFS_W   = 21;
    localparam int END_W   = OFS_W + 1;
    localparam int PAGES_W = $clog2(BATCH_BYTES / PAGE_BYTES) + 1;
    localparam int VALUE_W = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int MAX_RESULTS = 3;

    typedef enum logic [1:0] {
        CMD_BEGIN = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_END   = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_BYTE     = 3'd0,
        KIND_TAG      = 3'd1,
        KIND_LENGTH   = 3'd2,
        KIND_ZERO_RUN = 3'd3,
        KIND_DONE     = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_TOO_LARGE   = 2'd1,
        ST_NO_RECORD   = 2'd2,
        ST_OPEN_RECORD = 2'd3
    } status_t;

    typedef struct packed {
        kind_t               kind;
        logic [VALUE_W-1:0]  value;
        logic [OFS_W-1:0]    offset;
        status_t             status;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [1:0]                   count;
        result_t [MAX_RESULTS-1:0]    items;
    } queue_push_t;

    function automatic result_t make_item(kind_t kind, logic [VALUE_W-1:0] value,
                                          logic [OFS_W-1:0] offset, status_t status);
        result_t r;
        r.kind   = kind;
        r.value  = value;
        r.offset = offset;
        r.status = status;
        r.last   = 1'b0;
        return r;
    endfunction

endpackage

[rtl/plrf_result_queue.sv]
// ============================================================================
// Result queue
// Small queue that takes up to three results in one cycle and hands out one.
// ============================================================================
module plrf_result_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_en,
    input  plrf_pkg::queue_push_t  push,
    input  logic                   result_stall,
    output logic                   result_valid,
    output plrf_pkg::result_t      head,
    output logic                   has_room
);

    plrf_pkg::result_t                    entry_reg [plrf_pkg::QUEUE_DEPTH];
    logic [plrf_pkg::QPTR_W-1:0]          wr_ptr_reg;
    logic [plrf_pkg::QPTR_W-1:0]          wr_ptr_next;
    logic [plrf_pkg::QPTR_W-1:0]          rd_ptr_reg;
    logic [plrf_pkg::QPTR_W-1:0]          rd_ptr_next;
    logic [plrf_pkg::QPTR_W:0]            count_reg;
    logic [plrf_pkg::QPTR_W:0]            count_next;
    logic [1:0]                           push_n;
    logic                                 pop;

    assign push_n       = push_en ? push.count : 2'd0;
    assign pop          = result_valid && !result_stall;
    assign result_valid = (count_reg != '0);
    assign head         = entry_reg[rd_ptr_reg];
    assign has_room     = (count_reg <= (plrf_pkg::QPTR_W + 1)'(plrf_pkg::QUEUE_DEPTH
                                                               - plrf_pkg::MAX_RESULTS));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + plrf_pkg::QPTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + plrf_pkg::QPTR_W'(pop);
        count_next  = count_reg + (plrf_pkg::QPTR_W + 1)'(push_n)
                      - (plrf_pkg::QPTR_W + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < plrf_pkg::MAX_RESULTS; i++)
        begin
            if (2'(i) < push_n)
            begin
                entry_reg[wr_ptr_reg + plrf_pkg::QPTR_W'(i)] <= push.items[i];
            end
        end
    end

endmodule

[rtl/paged_log_record_framer.sv]
// ============================================================================
// Paged log record framer
// Packs log records into tagged pages with length words and end padding.
// ============================================================================
// One input request is taken per clock unless stalled. A request that
// yields one result (a data byte, a rejected command) keeps that rate; a
// begin-record or data request that also opens a page, or a batch end
// that pads, yields two or three results, and the input then stalls
// while the four-entry result queue drains at one result per unstalled
// cycle. The batch overflow check for a new record is done in the same
// cycle with shifts and a compare against the space left in the batch.
module paged_log_record_framer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [plrf_pkg::VALUE_W-1:0]      cfg_data,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [1:0]                        cmd,
    input  logic [plrf_pkg::LEN_W-1:0]        record_length,
    input  logic [7:0]                        data_byte,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [2:0]                        item_kind,
    output logic [plrf_pkg::VALUE_W-1:0]      item_value,
    output logic [plrf_pkg::OFS_W-1:0]        batch_offset,
    output logic [1:0]                        status,
    output logic                              last
);

    logic [plrf_pkg::VALUE_W-1:0]  sequence_tag_reg;
    logic [plrf_pkg::ROOM_W-1:0]   page_room_reg;
    logic [plrf_pkg::ROOM_W-1:0]   page_room_next;
    logic [plrf_pkg::OFS_W-1:0]    batch_length_reg;
    logic [plrf_pkg::OFS_W-1:0]    batch_length_next;
    logic [plrf_pkg::LEN_W-1:0]    record_left_reg;
    logic [plrf_pkg::LEN_W-1:0]    record_left_next;

    logic                          item_fire;
    logic                          has_room;
    plrf_pkg::queue_push_t         push;
    plrf_pkg::result_t             head;

    logic                          room_lt_word;
    logic [plrf_pkg::END_W-1:0]    page_end;
    logic [plrf_pkg::ROOM_W-1:0]   room_after_open;
    logic [plrf_pkg::ROOM_W-1:0]   room_for_record;
    logic                          over_end;
    logic [plrf_pkg::END_W-1:0]    spare;
    logic [plrf_pkg::PAGES_W-1:0]  spare_pages;
    logic [plrf_pkg::END_W-1:0]    record_limit;
    logic                          too_large;

    assign item_fire  = item_valid && !item_stall;
    assign item_stall = !has_room;

    // The batch is always page aligned at the end of the current page, so
    // the padded end after a record only depends on how many extra pages
    // the record spills into.
    always_comb
    begin
        room_lt_word    = (page_room_reg < plrf_pkg::ROOM_W'(plrf_pkg::WORD_BYTES));
        page_end        = plrf_pkg::END_W'(batch_length_reg)
                          + plrf_pkg::END_W'(page_room_reg)
                          + (room_lt_word ? plrf_pkg::END_W'(plrf_pkg::PAGE_BYTES) : '0);
        room_after_open = room_lt_word ? plrf_pkg::ROOM_W'(plrf_pkg::PAGE_BYTES)
                                       : page_room_reg;
        room_for_record = room_after_open - plrf_pkg::ROOM_W'(plrf_pkg::WORD_BYTES)
                          - ((room_after_open == plrf_pkg::ROOM_W'(plrf_pkg::PAGE_BYTES))
                             ? plrf_pkg::ROOM_W'(plrf_pkg::WORD_BYTES) : '0);
        over_end        = (page_end > plrf_pkg::END_W'(plrf_pkg::BATCH_BYTES));
        spare           = plrf_pkg::END_W'(plrf_pkg::BATCH_BYTES) - page_end;
        spare_pages     = plrf_pkg::PAGES_W'(spare >> plrf_pkg::PAGE_SHIFT);
        record_limit    = plrf_pkg::END_W'(room_for_record)
                          + (plrf_pkg::END_W'(spare_pages) << plrf_pkg::PAGE_SHIFT)
                          - (plrf_pkg::END_W'(spare_pages) << 2);
        too_large       = over_end
                          || (plrf_pkg::END_W'(record_length) > record_limit);
    end

    always_comb
    begin
        logic [plrf_pkg::ROOM_W-1:0] room_v;
        logic [plrf_pkg::OFS_W-1:0]  off_v;
        logic [1:0]                  slot;

        room_v            = page_room_reg;
        off_v             = batch_length_reg;
        slot              = 2'd0;
        push.items        = '0;
        page_room_next    = page_room_reg;
        batch_length_next = batch_length_reg;
        record_left_next  = record_left_reg;

        case (plrf_pkg::cmd_t'(cmd))
            plrf_pkg::CMD_BEGIN:
            begin
                if (record_left_reg != '0)
                begin
                    push.items[0] = plrf_pkg::make_item(plrf_pkg::KIND_LENGTH,
                        plrf_pkg::VALUE_W'(record_length), batch_length_reg,
                        plrf_pkg::ST_OPEN_RECORD);
                    slot = 2'd1;
                end
                else if (too_large)
                begin
                    push.items[0] = plrf_pkg::make_item(plrf_pkg::KIND_LENGTH,
                        plrf_pkg::VALUE_W'(record_length), batch_length_reg,
                        plrf_pkg::ST_TOO_LARGE);
                    slot = 2'd1;
                end
                else
                begin
                    if (room_lt_word)
                    begin
                        if (room_v != '0)
                        begin
                            push.items[slot] = plrf_pkg::make_item(plrf_pkg::KIND_ZERO_RUN,
                                plrf_pkg::VALUE_W'(room_v), off_v, plrf_pkg::ST_OK);
                            slot  = slot + 2'd1;
                            off_v = off_v + plrf_pkg::OFS_W'(room_v);
                        end
                        room_v = plrf_pkg::ROOM_W'(plrf_pkg::PAGE_BYTES);
                    end
                    if (room_v == plrf_pkg::ROOM_W'(plrf_pkg::PAGE_BYTES))
                    begin
                        push.items[slot] = plrf_pkg::make_item(plrf_pkg::KIND_TAG,
                            sequence_tag_reg, off_v, plrf_pkg::ST_OK);
                        slot   = slot + 2'd1;
                        off_v  = off_v + plrf_pkg::OFS_W'(plrf_pkg::WORD_BYTES);
                        room_v = room_v - plrf_pkg::ROOM_W'(plrf_pkg::WORD_BYTES);
                    end
                    push.items[slot] = plrf_pkg::make_item(plrf_pkg::KIND_LENGTH,
                        plrf_pkg::VALUE_W'(record_length), off_v, plrf_pkg::ST_OK);
                    slot              = slot + 2'd1;
                    off_v             = off_v + plrf_pkg::OFS_W'(plrf_pkg::WORD_BYTES);
                    room_v            = room_v - plrf_pkg::ROOM_W'(plrf_pkg::WORD_BYTES);
                    page_room_next    = room_v;
                    batch_length_next = off_v;
                    record_left_next  = record_length;
                end
            end
            plrf_pkg::CMD_DATA:
            begin
                if (record_left_reg == '0)
                begin
                    push.items[0] = plrf_pkg::make_item(plrf_pkg::KIND_BYTE,
                        plrf_pkg::VALUE_W'(data_byte), batch_length_reg,
                        plrf_pkg::ST_NO_RECORD);
                    slot = 2'd1;
                end
                else
                begin
                    if (room_v == '0)
                    begin
                        room_v = plrf_pkg::ROOM_W'(plrf_pkg::PAGE_BYTES);
                    end
                    if (room_v == plrf_pkg::ROOM_W'(plrf_pkg::PAGE_BYTES))
                    begin
                        push.items[slot] = plrf_pkg::make_item(plrf_pkg::KIND_TAG,
                            sequence_tag_reg, off_v, plrf_pkg::ST_OK);
                        slot   = slot + 2'd1;
                        off_v  = off_v + plrf_pkg::OFS_W'(plrf_pkg::WORD_BYTES);
                        room_v = room_v - plrf_pkg::ROOM_W'(plrf_pkg::WORD_BYTES);
                    end
                    push.items[slot] = plrf_pkg::make_item(plrf_pkg::KIND_BYTE,
                        plrf_pkg::VALUE_W'(data_byte), off_v, plrf_pkg::ST_OK);
                    slot              = slot + 2'd1;
                    page_room_next    = room_v - plrf_pkg::ROOM_W'(1);
                    batch_length_next = off_v + plrf_pkg::OFS_W'(1);
                    record_left_next  = record_left_reg - plrf_pkg::LEN_W'(1);
                end
            end
            plrf_pkg::CMD_END:
            begin
                if (record_left_reg != '0)
                begin
                    push.items[0] = plrf_pkg::make_item(plrf_pkg::KIND_DONE,
                        plrf_pkg::VALUE_W'(batch_length_reg), batch_length_reg,
                        plrf_pkg::ST_OPEN_RECORD);
                    slot = 2'd1;
                end
                else
                begin
                    if ((room_v != '0)
                        && (room_v != plrf_pkg::ROOM_W'(plrf_pkg::PAGE_BYTES)))
                    begin
                        push.items[slot] = plrf_pkg::make_item(plrf_pkg::KIND_ZERO_RUN,
                            plrf_pkg::VALUE_W'(room_v), off_v, plrf_pkg::ST_OK);
                        slot  = slot + 2'd1;
                        off_v = off_v + plrf_pkg::OFS_W'(room_v);
                    end
                    push.items[slot] = plrf_pkg::make_item(plrf_pkg::KIND_DONE,
                        plrf_pkg::VALUE_W'(off_v), off_v, plrf_pkg::ST_OK);
                    slot              = slot + 2'd1;
                    page_room_next    = plrf_pkg::ROOM_W'(plrf_pkg::PAGE_BYTES);
                    batch_length_next = '0;
                end
            end
            default:
            begin
                slot = 2'd0;
            end
        endcase

        for (int i = 0; i < plrf_pkg::MAX_RESULTS; i++)
        begin
            push.items[i].last = (2'(i + 1) == slot);
        end
        push.count = slot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sequence_tag_reg <= '0;
            page_room_reg    <= plrf_pkg::ROOM_W'(plrf_pkg::PAGE_BYTES);
            batch_length_reg <= '0;
            record_left_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                sequence_tag_reg <= cfg_data;
            end
            if (item_fire)
            begin
                page_room_reg    <= page_room_next;
                batch_length_reg <= batch_length_next;
                record_left_reg  <= record_left_next;
            end
        end
    end

    plrf_result_queue u_result_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_en      (item_fire),
        .push         (push),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .head         (head),
        .has_room     (has_room)
    );

    assign item_kind    = head.kind;
    assign item_value   = head.value;
    assign batch_offset = head.offset;
    assign status       = head.status;
    assign last         = head.last;

`ifndef SYNTHESIS
    logic [plrf_pkg::END_W-1:0] page_end_now;
    assign page_end_now = plrf_pkg::END_W'(batch_length_reg) + plrf_pkg::END_W'(page_room_reg);

    assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && (cmd == plrf_pkg::CMD_BEGIN || cmd == plrf_pkg::CMD_DATA
                       || cmd == plrf_pkg::CMD_END)) |-> (push.count != 2'd0))
        else $error("Accepted command produced no result.");

    assert property (@(posedge clk) disable iff (!rst_n)
        page_room_reg <= plrf_pkg::ROOM_W'(plrf_pkg::PAGE_BYTES))
        else $error("Page room exceeds the page size.");

    assert property (@(posedge clk) disable iff (!rst_n)
        ((page_end_now & plrf_pkg::END_W'(plrf_pkg::PAGE_BYTES - 1)) == '0)
        && (page_end_now <= plrf_pkg::END_W'(plrf_pkg::BATCH_BYTES)))
        else $error("Current page end is misaligned or beyond the batch.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && (record_left_reg != '0) && (cmd == plrf_pkg::CMD_DATA))
        |=> (record_left_reg == $past(record_left_reg) - plrf_pkg::LEN_W'(1)))
        else $error("Record byte count did not advance on a data byte.");
`endif

endmodule

[test/paged_log_record_framer_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// Paged log record framer testbench
// Drives begin, data and end requests with random gaps, stalls the result
// side at random, and checks each result against a local model of the page
// and batch framing. Directed requests cover the framing corner cases, then
// random phases with different sequence tags mix records, errors and noise.
// ============================================================================
module testbench;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]                  op;
        logic [plrf_pkg::LEN_W-1:0]  length;
        logic [7:0]                  data;
    } request_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_write = 1'b0;
    logic [plrf_pkg::VALUE_W-1:0]  cfg_data = '0;
    logic                          item_valid = 1'b0;
    logic                          item_stall;
    logic [1:0]                    cmd = '0;
    logic [plrf_pkg::LEN_W-1:0]    record_length = '0;
    logic [7:0]                    data_byte = '0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    logic [2:0]                    item_kind;
    logic [plrf_pkg::VALUE_W-1:0]  item_value;
    logic [plrf_pkg::OFS_W-1:0]    batch_offset;
    logic [1:0]                    status;
    logic                          last;

    request_t                      pending_requests[$];
    request_t                      current = '{op: CMD_UNUSED, length: '0, data: '0};
    plrf_pkg::result_t             expected_results[$];
    plrf_pkg::result_t             oldest;

    logic [plrf_pkg::ROOM_W-1:0]   page_left = plrf_pkg::ROOM_W'(plrf_pkg::PAGE_BYTES);
    logic [plrf_pkg::OFS_W-1:0]    batch_len = '0;
    logic [plrf_pkg::LEN_W-1:0]    record_left = '0;
    logic [plrf_pkg::VALUE_W-1:0]  tag_value = '0;

    bit                  driving = 1'b0;
    bit                  send_burst = 1'b0;
    bit                  stall_burst = 1'b0;
    int                  send_gap = 0;
    int                  stall_left = 0;
    int                  requests_taken = 0;
    int                  requests_retired = 0;
    int                  results_taken = 0;
    int                  results_seen = 0;
    int                  mismatches = 0;
    int                  cycle_count = 0;
    int                  cycle_limit = 50000;

    paged_log_record_framer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .cmd           (cmd),
        .record_length (record_length),
        .data_byte     (data_byte),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .item_kind     (item_kind),
        .item_value    (item_value),
        .batch_offset  (batch_offset),
        .status        (status),
        .last          (last)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void add_result(plrf_pkg::kind_t kind,
                                       logic [plrf_pkg::VALUE_W-1:0] value,
                                       plrf_pkg::status_t st);
        plrf_pkg::result_t r;
        r.kind   = kind;
        r.value  = value;
        r.offset = batch_len;
        r.status = st;
        r.last   = 1'b0;
        expected_results.push_back(r);
    endfunction

    // Batch length once a record of n bytes is placed and its page is padded out.
    function automatic longint unsigned padded_end(longint unsigned n);
        longint unsigned off;
        longint unsigned rm;
        longint unsigned rest;
        longint unsigned per;
        longint unsigned pages;
        off = batch_len;
        rm = page_left;
        if (rm < plrf_pkg::WORD_BYTES)
        begin
            off += rm;
            rm = plrf_pkg::PAGE_BYTES;
        end
        if (rm == plrf_pkg::PAGE_BYTES)
        begin
            off += plrf_pkg::WORD_BYTES;
            rm -= plrf_pkg::WORD_BYTES;
        end
        off += plrf_pkg::WORD_BYTES;
        rm -= plrf_pkg::WORD_BYTES;
        if (n <= rm)
        begin
            off += n;
            rm -= n;
        end
        else
        begin
            rest = n - rm;
            per = plrf_pkg::PAGE_BYTES - plrf_pkg::WORD_BYTES;
            pages = (rest + per - 1) / per;
            off += rm + plrf_pkg::WORD_BYTES * pages + rest;
            rm = pages * per - rest;
        end
        return off + rm;
    endfunction

    function automatic void open_page_if_needed();
        if (page_left == plrf_pkg::PAGE_BYTES)
        begin
            add_result(plrf_pkg::KIND_TAG, tag_value, plrf_pkg::ST_OK);
            batch_len += plrf_pkg::WORD_BYTES;
            page_left -= plrf_pkg::WORD_BYTES;
        end
    endfunction

    function automatic void frame_request(logic [1:0] op, logic [plrf_pkg::LEN_W-1:0] n,
                                          logic [7:0] d);
        int                queued;
        plrf_pkg::result_t r;
        queued = expected_results.size();
        case (op)
            plrf_pkg::CMD_BEGIN:
                if (record_left != 0)
                    add_result(plrf_pkg::KIND_LENGTH, plrf_pkg::VALUE_W'(n),
                               plrf_pkg::ST_OPEN_RECORD);
                else if (padded_end(n) > plrf_pkg::BATCH_BYTES)
                    add_result(plrf_pkg::KIND_LENGTH, plrf_pkg::VALUE_W'(n),
                               plrf_pkg::ST_TOO_LARGE);
                else
                begin
                    if (page_left < plrf_pkg::WORD_BYTES)
                    begin
                        if (page_left > 0)
                        begin
                            add_result(plrf_pkg::KIND_ZERO_RUN,
                                       plrf_pkg::VALUE_W'(page_left), plrf_pkg::ST_OK);
                            batch_len += page_left;
                        end
                        page_left = plrf_pkg::ROOM_W'(plrf_pkg::PAGE_BYTES);
                    end
                    open_page_if_needed();
                    add_result(plrf_pkg::KIND_LENGTH, plrf_pkg::VALUE_W'(n), plrf_pkg::ST_OK);
                    batch_len += plrf_pkg::WORD_BYTES;
                    page_left -= plrf_pkg::WORD_BYTES;
                    record_left = n;
                end
            plrf_pkg::CMD_DATA:
                if (record_left == 0)
                    add_result(plrf_pkg::KIND_BYTE, plrf_pkg::VALUE_W'(d),
                               plrf_pkg::ST_NO_RECORD);
                else
                begin
                    if (page_left == 0)
                        page_left = plrf_pkg::ROOM_W'(plrf_pkg::PAGE_BYTES);
                    open_page_if_needed();
                    add_result(plrf_pkg::KIND_BYTE, plrf_pkg::VALUE_W'(d), plrf_pkg::ST_OK);
                    batch_len += 1;
                    page_left -= 1;
                    record_left -= 1;
                end
            plrf_pkg::CMD_END:
                if (record_left != 0)
                    add_result(plrf_pkg::KIND_DONE, plrf_pkg::VALUE_W'(batch_len),
                               plrf_pkg::ST_OPEN_RECORD);
                else
                begin
                    if (page_left > 0 && page_left < plrf_pkg::PAGE_BYTES)
                    begin
                        add_result(plrf_pkg::KIND_ZERO_RUN, plrf_pkg::VALUE_W'(page_left),
                                   plrf_pkg::ST_OK);
                        batch_len += page_left;
                    end
                    add_result(plrf_pkg::KIND_DONE, plrf_pkg::VALUE_W'(batch_len),
                               plrf_pkg::ST_OK);
                    batch_len = '0;
                    page_left = plrf_pkg::ROOM_W'(plrf_pkg::PAGE_BYTES);
                end
            default:
                ;
        endcase
        if (expected_results.size() > queued)
        begin
            r = expected_results.pop_back();
            r.last = 1'b1;
            expected_results.push_back(r);
        end
    endfunction

    function automatic int draw_wait(inout bit burst);
        if ($urandom_range(0, 29) == 0)
            burst = !burst;
        return burst ? 0 : int'($urandom_range(0, 19));
    endfunction

    // Request driver: a new request goes out once the previous one is taken
    // and its gap has run out.
    always @(negedge clk)
    begin
        if (requests_taken != requests_retired)
        begin
            requests_retired = requests_taken;
            driving = 1'b0;
            send_gap = draw_wait(send_burst);
        end
        if (rst_n && !driving)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (pending_requests.size() > 0)
            begin
                current = pending_requests[0];
                pending_requests.delete(0);
                driving = 1'b1;
            end
        end
        item_valid    <= driving;
        cmd           <= current.op;
        record_length <= current.length;
        data_byte     <= current.data;
    end

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
        begin
            frame_request(cmd, record_length, data_byte);
            requests_taken++;
        end
    end

    always @(negedge clk)
    begin
        if (results_taken != results_seen)
        begin
            results_seen = results_taken;
            stall_left = draw_wait(stall_burst);
        end
        if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_taken++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d value %0h offset %0d status %0d",
                             item_kind, item_value, batch_offset, status,
                             " last %0d", last);
            end
            else
            begin
                oldest = expected_results[0];
                expected_results.delete(0);
                if (item_kind !== oldest.kind || item_value !== oldest.value ||
                    batch_offset !== oldest.offset || status !== oldest.status ||
                    last !== oldest.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected kind %0d value %0h offset %0d",
                                 oldest.kind, oldest.value, oldest.offset,
                                 " status %0d last %0d,", oldest.status, oldest.last,
                                 " got kind %0d value %0h offset %0d",
                                 item_kind, item_value, batch_offset,
                                 " status %0d last %0d", status, last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void queue_request(logic [1:0] op,
                                          logic [plrf_pkg::LEN_W-1:0] length,
                                          logic [7:0] data);
        request_t q;
        q.op = op;
        q.length = length;
        q.data = data;
        pending_requests.push_back(q);
        cycle_limit += 300;
    endfunction

    function automatic void queue_record(int n);
        queue_request(plrf_pkg::CMD_BEGIN, plrf_pkg::LEN_W'(n), 8'($urandom_range(0, 255)));
        repeat (n)
            queue_request(plrf_pkg::CMD_DATA, plrf_pkg::LEN_W'($urandom_range(0, 1048576)),
                          8'($urandom_range(0, 255)));
    endfunction

    // The block can still be busy with a request that produces no result, so
    // the wait runs on past the last expected result.
    task automatic wait_idle();
        @(posedge clk);
        while (pending_requests.size() != 0 || driving || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_tag(logic [plrf_pkg::VALUE_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        tag_value = value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Queues a record sized so that the page has target bytes left after it.
    task automatic queue_spanning_record(int target);
        int room_after;
        wait_idle();
        if (page_left < plrf_pkg::WORD_BYTES || page_left == plrf_pkg::PAGE_BYTES)
            room_after = plrf_pkg::PAGE_BYTES - 2 * plrf_pkg::WORD_BYTES;
        else
            room_after = int'(page_left) - plrf_pkg::WORD_BYTES;
        if (room_after >= target)
            queue_record(room_after - target);
        else
            queue_record(room_after + plrf_pkg::PAGE_BYTES - plrf_pkg::WORD_BYTES - target);
    endtask

    initial
    begin : stimulus
        logic [plrf_pkg::VALUE_W-1:0] phase_tag[6];
        int count;
        int pick;
        int n;
        int k;
        int spans_left;

        phase_tag[0] = $urandom();
        phase_tag[1] = 32'h0000_0000;
        phase_tag[2] = 32'h8000_0001;
        phase_tag[3] = $urandom();
        phase_tag[4] = 32'hFFFF_FFFF;
        phase_tag[5] = $urandom();
        spans_left = 4;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_request(plrf_pkg::CMD_END, '0, '0);
        queue_request(CMD_UNUSED, plrf_pkg::LEN_W'(1048576), 8'hFF);
        queue_request(plrf_pkg::CMD_DATA, '0, 8'hFF);
        queue_request(plrf_pkg::CMD_BEGIN, plrf_pkg::LEN_W'(1048576), 8'h00);
        queue_request(plrf_pkg::CMD_BEGIN, plrf_pkg::LEN_W'(1047549), 8'h00);
        queue_request(plrf_pkg::CMD_BEGIN, '0, 8'h00);
        queue_request(plrf_pkg::CMD_BEGIN, plrf_pkg::LEN_W'(3), 8'h00);
        queue_request(plrf_pkg::CMD_BEGIN, plrf_pkg::LEN_W'(5), 8'h00);
        queue_request(plrf_pkg::CMD_END, '0, 8'h00);
        queue_request(plrf_pkg::CMD_DATA, '0, 8'h00);
        queue_request(plrf_pkg::CMD_DATA, '0, 8'hA5);
        queue_request(plrf_pkg::CMD_DATA, '0, 8'hFF);
        queue_request(plrf_pkg::CMD_END, '0, 8'h00);

        write_tag(32'hFFFF_FFFF);
        queue_spanning_record(0);
        queue_request(plrf_pkg::CMD_DATA, '0, 8'h5A);
        queue_record(2);
        queue_spanning_record(2);
        queue_record(1);
        queue_spanning_record(plrf_pkg::PAGE_BYTES - 6);
        write_tag(32'h1234_5678);
        queue_spanning_record(0);
        queue_request(plrf_pkg::CMD_END, '0, '0);

        for (int p = 0; p < 6; p++)
        begin
            write_tag(phase_tag[p]);
            count = 0;
            while (count < 52)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    n = $urandom_range(0, 12);
                    queue_record(n);
                    count += n + 1;
                end
                else if (pick < 65)
                begin
                    queue_request(plrf_pkg::CMD_END,
                                  plrf_pkg::LEN_W'($urandom_range(0, 1048576)),
                                  8'($urandom_range(0, 255)));
                    count++;
                end
                else if (pick < 75)
                begin
                    case ($urandom_range(0, 2))
                        0: queue_request(CMD_UNUSED,
                                         plrf_pkg::LEN_W'($urandom_range(0, 1048576)),
                                         8'($urandom_range(0, 255)));
                        1:
                        begin
                            queue_request(plrf_pkg::CMD_DATA,
                                          plrf_pkg::LEN_W'($urandom_range(0, 1048576)),
                                          8'($urandom_range(0, 255)));
                            count++;
                        end
                        default:
                        begin
                            queue_request(plrf_pkg::CMD_BEGIN,
                                          plrf_pkg::LEN_W'($urandom_range(1047549, 1048576)),
                                          8'($urandom_range(0, 255)));
                            count++;
                        end
                    endcase
                end
                else if (pick < 95)
                begin
                    n = $urandom_range(2, 10);
                    k = $urandom_range(1, n - 1);
                    queue_request(plrf_pkg::CMD_BEGIN, plrf_pkg::LEN_W'(n),
                                  8'($urandom_range(0, 255)));
                    repeat (k)
                        queue_request(plrf_pkg::CMD_DATA, '0, 8'($urandom_range(0, 255)));
                    case ($urandom_range(0, 2))
                        0: queue_request(plrf_pkg::CMD_BEGIN,
                                         plrf_pkg::LEN_W'($urandom_range(0, 1048576)),
                                         8'($urandom_range(0, 255)));
                        1: queue_request(plrf_pkg::CMD_END, '0, 8'($urandom_range(0, 255)));
                        default: queue_request(CMD_UNUSED, '0, 8'($urandom_range(0, 255)));
                    endcase
                    repeat (n - k)
                        queue_request(plrf_pkg::CMD_DATA, '0, 8'($urandom_range(0, 255)));
                    count += n + 2;
                end
                else if (spans_left > 0)
                begin
                    spans_left--;
                    if ($urandom_range(0, 1) == 0)
                        queue_spanning_record($urandom_range(0, 5));
                    else
                        queue_spanning_record($urandom_range(plrf_pkg::PAGE_BYTES - 8,
                                                             plrf_pkg::PAGE_BYTES - 5));
                end
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
